/* hdl/iteration_count_transfer_defines.svh */
// ---------------------------------------------------------------------------
// iteration count transfer assertion macros
// shared concurrent check forms, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ITERATION_COUNT_TRANSFER_DEFINES_SVH
`define ITERATION_COUNT_TRANSFER_DEFINES_SVH

// same-cycle implication
`define ITC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itc check failed");

// next-cycle implication
`define ITC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itc check failed");

`endif

/* hdl/itc_pkg.sv */
// ---------------------------------------------------------------------------
// itc_pkg
// widths, curve codes and pipeline geometry of the iteration count transfer
// ---------------------------------------------------------------------------
`default_nettype none

package itc_pkg;

  // fixed point format
  localparam int WORD_W    = 40;
  localparam int FRAC_BITS = 16;

  // curve select codes
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SQRT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CBRT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOG    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RESET  = MODE_LINEAR;

  // register map
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] ADDR_MODE = 3'd0;

  // square root: two radicand bits per stage
  localparam int SQ_N  = (WORD_W + FRAC_BITS + 1) / 2;
  localparam int SQ_RW = SQ_N + 2;

  // cube root: three radicand bits per stage
  localparam int CB_N  = (WORD_W + 2 * FRAC_BITS + 2) / 3;
  localparam int CB_RW = 2 * CB_N + 3;
  localparam int CB_AW = CB_RW + 3;

  // logarithm by repeated squaring
  localparam int LOG_FRAC = 56;
  localparam int M_W      = 63;
  localparam int P_W      = 6;
  localparam int WH_W     = LOG_FRAC + P_W;
  localparam int LG_SH    = 64 + LOG_FRAC - FRAC_BITS;
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

  // stage 0 input, 1 msb search, 2 normalize, two per squaring,
  // one product stage, last stage is the output register
  localparam int NSTG = 2 * LOG_FRAC + 4;

endpackage

`default_nettype wire

/* hdl/itc_ifs.sv */
// ---------------------------------------------------------------------------
// itc channel interfaces
// valid/ready word channels for counts in and adjusted counts out
// ---------------------------------------------------------------------------
`default_nettype none

interface itc_in_if;
  import itc_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

interface itc_out_if;
  import itc_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] adjusted_count;

  modport source (output valid, output adjusted_count, input ready);
  modport sink   (input valid, input adjusted_count, output ready);
endinterface

`default_nettype wire

/* hdl/iteration_count_transfer.sv */
// ---------------------------------------------------------------------------
// iteration_count_transfer
// square root, cube root, ln or copy of a 24.16 count, fully pipelined
// ---------------------------------------------------------------------------
// Takes one word per clock and returns one word per clock, in order, while
// the output is not stalled. The depth of the pipe is set by the logarithm
// path: 56 squarings of the normalized mantissa, each spread over a
// partial-product stage and a sum stage. Square and cube roots are computed
// digit by digit alongside it and carried to the output. The whole pipe
// advances whenever the output register is empty or being taken and freezes
// as one otherwise, so a stall loses and repeats nothing. Write transfer_mode
// only while no words are in flight.
// ---------------------------------------------------------------------------
`default_nettype none
`include "iteration_count_transfer_defines.svh"

module iteration_count_transfer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  itc_in_if.sink                           in_ch,
  itc_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [itc_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [itc_pkg::CFG_DW-1:0]  pwdata,
  output logic      [itc_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready
);
  import itc_pkg::*;

  logic [MODE_W-1:0]  transfer_mode_r;
  logic               en;
  logic [NSTG:0]      v_r;
  logic [WORD_W-1:0]  x_r       [0:NSTG-1];
  logic [WORD_W-1:0]  res_r;

  logic [SQ_RW-1:0]   sq_rem_r  [0:SQ_N];
  logic [SQ_N-1:0]    sq_root_r [0:NSTG-1];

  logic [CB_RW-1:0]   cb_rem_r  [0:CB_N];
  logic [2*CB_N-1:0]  cb_sq_r   [0:CB_N];
  logic [CB_N-1:0]    cb_root_r [0:NSTG-1];

  logic [P_W-1:0]     lg_p_r    [0:NSTG-1];
  logic               lg_z_r    [0:NSTG-1];
  logic [M_W-1:0]     lg_m_r    [0:NSTG-1];
  logic [LOG_FRAC-1:0] lg_fr_r  [0:NSTG-1];
  logic [63:0]        lg_hh_r   [0:NSTG-1];
  logic [63:0]        lg_hl_r   [0:NSTG-1];
  logic [63:0]        lg_ll_r   [0:NSTG-1];
  logic [63:0]        fin_11_r, fin_10_r, fin_01_r, fin_00_r;

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transfer_mode_r <= MODE_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_MODE)) begin
      transfer_mode_r <= pwdata[MODE_W-1:0];
    end
  end
  assign prdata = (paddr == ADDR_MODE) ? CFG_DW'(transfer_mode_r) : '0;

  // global advance: output empty or being taken
  assign en           = !v_r[NSTG] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = v_r[NSTG];
  assign out_ch.adjusted_count = res_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-1:0], in_ch.valid};
    end
  end

  genvar s;
  generate
    for (s = 0; s < NSTG; s++) begin : g_stg
      // raw count travels with the word
      always_ff @(posedge clk) begin
        if (en) begin
          if (s == 0) x_r[s] <= in_ch.iteration_count;
          else        x_r[s] <= x_r[(s == 0) ? 0 : s-1];
        end
      end

      // square root lane
      if (s == 0) begin : g_sq0
        always_ff @(posedge clk) begin
          if (en) begin
            sq_rem_r[0]  <= '0;
            sq_root_r[0] <= '0;
          end
        end
      end else if (s <= SQ_N) begin : g_sq
        localparam int G = SQ_N - s;
        logic [2*SQ_N-1:0] tt;
        logic [SQ_RW+1:0]  ra, tr;
        logic [SQ_RW-1:0]  rem_nxt;
        logic [SQ_N-1:0]   root_nxt;
        always_comb begin
          tt = (2*SQ_N)'({x_r[s-1], {FRAC_BITS{1'b0}}});
          ra = {sq_rem_r[s-1], tt[2*G +: 2]};
          tr = (SQ_RW+2)'({sq_root_r[s-1], 2'b01});
          if (ra >= tr) begin
            rem_nxt  = SQ_RW'(ra - tr);
            root_nxt = {sq_root_r[s-1][SQ_N-2:0], 1'b1};
          end else begin
            rem_nxt  = SQ_RW'(ra);
            root_nxt = {sq_root_r[s-1][SQ_N-2:0], 1'b0};
          end
        end
        always_ff @(posedge clk) begin
          if (en) begin
            sq_rem_r[s]  <= rem_nxt;
            sq_root_r[s] <= root_nxt;
          end
        end
      end else begin : g_sqc
        always_ff @(posedge clk) begin
          if (en) sq_root_r[s] <= sq_root_r[s-1];
        end
      end

      // cube root lane, keeps root and root squared
      if (s == 0) begin : g_cb0
        always_ff @(posedge clk) begin
          if (en) begin
            cb_rem_r[0]  <= '0;
            cb_sq_r[0]   <= '0;
            cb_root_r[0] <= '0;
          end
        end
      end else if (s <= CB_N) begin : g_cb
        localparam int G = CB_N - s;
        logic [3*CB_N-1:0] tt;
        logic [CB_AW-1:0]  ra, b;
        logic [CB_RW-1:0]  rem_nxt;
        logic [CB_N-1:0]   root_nxt;
        logic [2*CB_N-1:0] sq_nxt;
        always_comb begin
          tt = (3*CB_N)'({x_r[s-1], {(2*FRAC_BITS){1'b0}}});
          ra = {cb_rem_r[s-1], tt[3*G +: 3]};
          b  = CB_AW'({cb_sq_r[s-1], 3'b000}) + CB_AW'({cb_sq_r[s-1], 2'b00})
             + CB_AW'({cb_root_r[s-1], 2'b00}) + CB_AW'({cb_root_r[s-1], 1'b0})
             + CB_AW'(1);
          if (ra >= b) begin
            rem_nxt  = CB_RW'(ra - b);
            root_nxt = {cb_root_r[s-1][CB_N-2:0], 1'b1};
            sq_nxt   = (2*CB_N)'({cb_sq_r[s-1], 2'b00})
                     + (2*CB_N)'({cb_root_r[s-1], 2'b00}) + (2*CB_N)'(1);
          end else begin
            rem_nxt  = CB_RW'(ra);
            root_nxt = {cb_root_r[s-1][CB_N-2:0], 1'b0};
            sq_nxt   = (2*CB_N)'({cb_sq_r[s-1], 2'b00});
          end
        end
        always_ff @(posedge clk) begin
          if (en) begin
            cb_rem_r[s]  <= rem_nxt;
            cb_sq_r[s]   <= sq_nxt;
            cb_root_r[s] <= root_nxt;
          end
        end
      end else begin : g_cbc
        always_ff @(posedge clk) begin
          if (en) cb_root_r[s] <= cb_root_r[s-1];
        end
      end

      // log lane
      if (s == 1) begin : g_lgp
        logic [P_W-1:0] p;
        always_comb begin
          p = '0;
          for (int i = 0; i < WORD_W; i++) begin
            if (x_r[0][i]) p = P_W'(i);
          end
        end
        always_ff @(posedge clk) begin
          if (en) begin
            lg_p_r[s] <= p;
            lg_z_r[s] <= (x_r[0][WORD_W-1:FRAC_BITS] == '0);
          end
        end
      end else if (s == 2) begin : g_lgn
        always_ff @(posedge clk) begin
          if (en) begin
            lg_p_r[s]  <= lg_p_r[s-1];
            lg_z_r[s]  <= lg_z_r[s-1];
            lg_m_r[s]  <= M_W'(x_r[s-1]) << (P_W'(M_W - 1) - lg_p_r[s-1]);
            lg_fr_r[s] <= '0;
          end
        end
      end else if (s >= 3 && s < NSTG-1 && ((s - 3) % 2 == 0)) begin : g_lgm
        // partial products of the mantissa square
        logic [30:0] mh;
        logic [31:0] ml;
        assign mh = lg_m_r[s-1][M_W-1:32];
        assign ml = lg_m_r[s-1][31:0];
        always_ff @(posedge clk) begin
          if (en) begin
            lg_p_r[s]  <= lg_p_r[s-1];
            lg_z_r[s]  <= lg_z_r[s-1];
            lg_fr_r[s] <= lg_fr_r[s-1];
            lg_hh_r[s] <= 64'(mh) * 64'(mh);
            lg_hl_r[s] <= 64'(mh) * 64'(ml);
            lg_ll_r[s] <= 64'(ml) * 64'(ml);
          end
        end
      end else if (s >= 4 && s < NSTG-1) begin : g_lgs
        // sum, rescale and take one fraction bit
        logic [127:0] sq;
        logic [63:0]  mn;
        always_comb begin
          sq = (128'(lg_hh_r[s-1]) << 64) + (128'(lg_hl_r[s-1]) << 33)
             + 128'(lg_ll_r[s-1]);
          mn = sq[125:62];
        end
        always_ff @(posedge clk) begin
          if (en) begin
            lg_p_r[s]  <= lg_p_r[s-1];
            lg_z_r[s]  <= lg_z_r[s-1];
            lg_fr_r[s] <= {lg_fr_r[s-1][LOG_FRAC-2:0], mn[63]};
            lg_m_r[s]  <= mn[63] ? mn[63:1] : mn[62:0];
          end
        end
      end else if (s == NSTG-1) begin : g_lgf
        // log2 times ln 2, partial products
        logic [WH_W-1:0] whole;
        logic [P_W-1:0]  pexp;
        always_comb begin
          pexp  = lg_p_r[s-1] - P_W'(FRAC_BITS);
          whole = {pexp, lg_fr_r[s-1]};
        end
        always_ff @(posedge clk) begin
          if (en) begin
            lg_z_r[s] <= lg_z_r[s-1];
            fin_11_r  <= 64'(whole[WH_W-1:32]) * 64'(LN2_Q64[63:32]);
            fin_10_r  <= 64'(whole[WH_W-1:32]) * 64'(LN2_Q64[31:0]);
            fin_01_r  <= 64'(whole[31:0]) * 64'(LN2_Q64[63:32]);
            fin_00_r  <= 64'(whole[31:0]) * 64'(LN2_Q64[31:0]);
          end
        end
      end
    end
  endgenerate

  // output stage: finish the log product and pick the curve
  logic [127:0]      lg_sum;
  logic [WORD_W-1:0] lg_val;
  logic [WORD_W-1:0] res_nxt;
  always_comb begin
    lg_sum = (128'(fin_11_r) << 64) + (128'(fin_10_r) << 32)
           + (128'(fin_01_r) << 32) + 128'(fin_00_r);
    lg_val = WORD_W'(lg_sum >> LG_SH);
    unique case (transfer_mode_r)
      MODE_SQRT: res_nxt = WORD_W'(sq_root_r[NSTG-1]);
      MODE_CBRT: res_nxt = WORD_W'(cb_root_r[NSTG-1]);
      MODE_LOG:  res_nxt = lg_z_r[NSTG-1] ? '0 : lg_val;
      default:   res_nxt = x_r[NSTG-1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  // result ranges per curve and pipe movement
  `ITC_ASSERT(a_sqrt_range, v_r[NSTG] && transfer_mode_r == MODE_SQRT, res_r[WORD_W-1:SQ_N] == '0)
  `ITC_ASSERT(a_cbrt_range, v_r[NSTG] && transfer_mode_r == MODE_CBRT, res_r[WORD_W-1:CB_N] == '0)
  `ITC_ASSERT(a_log_range, v_r[NSTG] && transfer_mode_r == MODE_LOG, res_r[WORD_W-1:FRAC_BITS+5] == '0)
  `ITC_ASSERT_NEXT(a_advance, v_r[NSTG-1] && en, out_ch.valid)

endmodule

`default_nettype wire
